// File: src/srdc_pkg.sv
// Package: shared constants, codes and structures of the SLIP reply deframer.
package srdc_pkg;

   localparam int COUNT_W        = 11;
   localparam int MAX_FRAME_BYTES = 1024;
   localparam int HEADER_BYTES   = 6;
   localparam int INDEX_W        = 10;

   localparam logic [7:0] SL_END     = 8'hC0;
   localparam logic [7:0] SL_ESC     = 8'hDB;
   localparam logic [7:0] SL_ESC_END = 8'hDC;
   localparam logic [7:0] SL_ESC_ESC = 8'hDD;
   localparam logic [7:0] ACK_CODE   = 8'h06;

   localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(MAX_FRAME_BYTES);
   localparam logic [COUNT_W-1:0] OVER_COUNT    = COUNT_W'(MAX_FRAME_BYTES + 1);
   localparam logic [COUNT_W-1:0] HEADER_COUNT  = COUNT_W'(HEADER_BYTES);
   localparam logic [COUNT_W-1:0] CAPACITY_INIT = COUNT_W'(1024);

   localparam logic [COUNT_W-1:0] POS_COMMAND = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_LEN_LO  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_LEN_HI  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_CHECK   = COUNT_W'(4);

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_FRAME   = 2'd1,
      PH_ESCAPED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LENGTH_BAD = 2'd1,
      ST_CHECK_BAD  = 2'd2,
      ST_NOT_ACK    = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } step_type;

   typedef struct packed {
      logic                 hit;
      logic                 kind;
      logic [7:0]           data_byte;
      logic [INDEX_W-1:0]   data_index;
      status_type           status;
      logic [7:0]           reply_command;
      logic [COUNT_W-1:0]   frame_length;
   } result_type;

endpackage

// File: src/srdc_req_if.sv
// Interface: received byte channel with valid/ready handshake.
interface srdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/srdc_rsp_if.sv
// Interface: result channel carrying payload bytes and end-of-frame status.
interface srdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [7:0]                    data_byte;
   logic [srdc_pkg::INDEX_W-1:0]  data_index;
   logic [1:0]                    status;
   logic [7:0]                    reply_command;
   logic [srdc_pkg::COUNT_W-1:0]  frame_length;

   modport source (output valid, output kind, output data_byte, output data_index,
                   output status, output reply_command, output frame_length,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input data_index,
                 input status, input reply_command, input frame_length,
                 output ready);
endinterface

// File: src/srdc_input_stage.sv
// Input register: holds one received byte until the decoder takes it.
module srdc_input_stage (
   input  logic               clock,
   input  logic               reset,
   srdc_req_if.sink           req_bus,
   input  logic               advance,
   output srdc_pkg::step_type step
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_bus.ready = !valid_ff || advance;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_bus.rx_byte;
      end
   end

   assign step.valid   = valid_ff;
   assign step.rx_byte = byte_ff;

endmodule

// File: src/srdc_decoder.sv
// Decoder: frame phase, SLIP unescaping, header capture, checksum and status.
module srdc_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  srdc_pkg::step_type              step,
   input  logic                            advance,
   input  logic                            csr_wr_en,
   input  logic [srdc_pkg::COUNT_W-1:0]    csr_wr_data,
   output srdc_pkg::result_type            result
);

   srdc_pkg::phase_type             phase_ff, phase_in;
   logic [srdc_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [7:0]                      sum_ff, sum_in;
   logic [15:0]                     length_ff, length_in;
   logic [7:0]                      command_ff, command_in;
   logic [7:0]                      check_ff, check_in;
   logic [srdc_pkg::COUNT_W-1:0]    capacity_ff;

   logic       take;
   logic       close;
   logic       open;
   logic [7:0] dbyte;
   logic [7:0] add;
   logic [8:0] sum_wide;
   logic [srdc_pkg::COUNT_W-1:0] offset;
   logic [srdc_pkg::COUNT_W-1:0] shown;
   srdc_pkg::status_type status;

   // Phase and byte classification
   always_comb begin
      phase_in = phase_ff;
      take     = 1'b0;
      close    = 1'b0;
      open     = 1'b0;
      dbyte    = step.rx_byte;
      case (phase_ff)
         srdc_pkg::PH_FRAME: begin
            if (step.rx_byte == srdc_pkg::SL_END) begin
               close    = 1'b1;
               phase_in = srdc_pkg::PH_HUNT;
            end else if (step.rx_byte == srdc_pkg::SL_ESC) begin
               phase_in = srdc_pkg::PH_ESCAPED;
            end else begin
               take = 1'b1;
            end
         end
         srdc_pkg::PH_ESCAPED: begin
            if (step.rx_byte == srdc_pkg::SL_END) begin
               close    = 1'b1;
               phase_in = srdc_pkg::PH_HUNT;
            end else begin
               take     = 1'b1;
               phase_in = srdc_pkg::PH_FRAME;
               if (step.rx_byte == srdc_pkg::SL_ESC_END) begin
                  dbyte = srdc_pkg::SL_END;
               end else if (step.rx_byte == srdc_pkg::SL_ESC_ESC) begin
                  dbyte = srdc_pkg::SL_ESC;
               end
            end
         end
         default: begin
            if (step.rx_byte == srdc_pkg::SL_END) begin
               open     = 1'b1;
               phase_in = srdc_pkg::PH_FRAME;
            end else begin
               phase_in = srdc_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // Frame state and result
   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      command_in = command_ff;
      check_in   = check_ff;
      add        = (count_ff == srdc_pkg::POS_CHECK) ? 8'h00 : dbyte;
      sum_wide   = {1'b0, sum_ff} + {1'b0, add};
      offset     = count_ff - srdc_pkg::HEADER_COUNT;
      shown      = (count_ff > srdc_pkg::MAX_COUNT) ? srdc_pkg::MAX_COUNT : count_ff;

      if (count_ff < srdc_pkg::HEADER_COUNT || count_ff > srdc_pkg::MAX_COUNT ||
          {5'd0, count_ff} != length_ff) begin
         status = srdc_pkg::ST_LENGTH_BAD;
      end else if (check_ff != sum_ff) begin
         status = srdc_pkg::ST_CHECK_BAD;
      end else if (command_ff != srdc_pkg::ACK_CODE) begin
         status = srdc_pkg::ST_NOT_ACK;
      end else begin
         status = srdc_pkg::ST_OK;
      end

      result               = '0;
      result.kind          = srdc_pkg::KIND_DATA;
      result.status        = srdc_pkg::ST_OK;

      if (open) begin
         count_in   = '0;
         sum_in     = '0;
         length_in  = '0;
         command_in = '0;
         check_in   = '0;
      end else if (close) begin
         result.hit           = step.valid;
         result.kind          = srdc_pkg::KIND_STATUS;
         result.status        = status;
         result.reply_command = command_ff;
         result.frame_length  = shown;
      end else if (take) begin
         if (count_ff >= srdc_pkg::MAX_COUNT) begin
            count_in = srdc_pkg::OVER_COUNT;
         end else begin
            if (count_ff == srdc_pkg::POS_COMMAND) begin
               command_in = dbyte;
            end
            if (count_ff == srdc_pkg::POS_LEN_LO) begin
               length_in = {length_ff[15:8], dbyte};
            end
            if (count_ff == srdc_pkg::POS_LEN_HI) begin
               length_in = {dbyte, length_ff[7:0]};
            end
            if (count_ff == srdc_pkg::POS_CHECK) begin
               check_in = dbyte;
            end
            sum_in   = sum_wide[7:0] + {7'd0, sum_wide[8]};
            count_in = count_ff + 1'b1;
            if (count_ff >= srdc_pkg::HEADER_COUNT && offset < capacity_ff) begin
               result.hit        = step.valid;
               result.data_byte  = dbyte;
               result.data_index = offset[srdc_pkg::INDEX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= srdc_pkg::PH_HUNT;
         count_ff    <= '0;
         sum_ff      <= '0;
         length_ff   <= '0;
         command_ff  <= '0;
         check_ff    <= '0;
         capacity_ff <= srdc_pkg::CAPACITY_INIT;
      end else begin
         if (advance) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            sum_ff     <= sum_in;
            length_ff  <= length_in;
            command_ff <= command_in;
            check_ff   <= check_in;
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

endmodule

// File: src/srdc_result_stage.sv
// Result register: holds one result until the consumer takes it.
module srdc_result_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  srdc_pkg::result_type result,
   srdc_rsp_if.source           rsp_bus
);

   logic                 valid_ff;
   logic                 valid_in;
   srdc_pkg::result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.kind          = data_ff.kind;
   assign rsp_bus.data_byte     = data_ff.data_byte;
   assign rsp_bus.data_index    = data_ff.data_index;
   assign rsp_bus.status        = data_ff.status;
   assign rsp_bus.reply_command = data_ff.reply_command;
   assign rsp_bus.frame_length  = data_ff.frame_length;

endmodule

// File: src/slip_reply_deframe_checker_core.sv
// Top level: SLIP reply deframer with header and checksum checking.
//
// req_bus carries raw serial bytes; rsp_bus carries decoded payload bytes
// (kind 0, with their payload index) and one status transfer per frame
// (kind 1) at the closing 0xC0. Bytes before an opening 0xC0 are dropped.
// csr_wr_en/csr_wr_data set the reply capacity, the most payload bytes
// passed out per frame; write it only while the block is idle.
// A byte accepted on req_bus waits in the input register and is decoded
// there; its result, if any, goes into the result register, which drives
// rsp_bus. Throughput: one byte per cycle while rsp_bus is not stalled,
// set by the single decode step between the input and result registers.
// Reset clears the frame state to hunting and the capacity to 1024.
// When the receiver stalls, a pending result holds in the result register
// and one more byte is held in the input register; req_bus.ready drops
// only when both are occupied and the held byte would give a result.
module slip_reply_deframe_checker_core (
   input  logic                          clock,
   input  logic                          reset,
   srdc_req_if.sink                      req_bus,
   srdc_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [srdc_pkg::COUNT_W-1:0]  csr_wr_data
);

   srdc_pkg::step_type   step;
   srdc_pkg::result_type result;
   logic                 advance;
   logic                 load;

   assign advance = step.valid && (!result.hit || !rsp_bus.valid || rsp_bus.ready);
   assign load    = advance && result.hit;

   srdc_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .step    (step)
   );

   srdc_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .advance     (advance),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   srdc_result_stage u_result (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .result  (result),
      .rsp_bus (rsp_bus)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result register overwritten before transfer");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == srdc_pkg::KIND_STATUS)
         |-> (rsp_bus.data_byte == 8'h00 && rsp_bus.data_index == '0))
      else $error("status transfer carries payload fields");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == srdc_pkg::KIND_STATUS &&
       rsp_bus.status == srdc_pkg::ST_OK)
         |-> (rsp_bus.frame_length >= srdc_pkg::HEADER_COUNT &&
              rsp_bus.reply_command == srdc_pkg::ACK_CODE))
      else $error("ok status on a short or non-ACK frame");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == srdc_pkg::KIND_DATA)
         |-> (rsp_bus.frame_length == '0 && rsp_bus.reply_command == 8'h00))
      else $error("payload transfer carries status fields");

endmodule
